@@ hw/rtl/lrct_pkg.sv @@
// Package for the learned remote code table: item types, command and event
// codes, sequencer states and small helper functions.
// Depends on nothing; the core and the testbench import it.
package lrct_pkg;

  localparam int SLOTS      = 128;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CODE_W     = 32;
  localparam int TICKET_W   = 10;
  localparam int WINDOW_W   = 7;
  localparam int QUEUE_MOD  = 1000;
  localparam int WINDOW_MAX = 99;

  localparam logic [CODE_W-1:0] KEY_MASK = 32'hFFFF_FCFF;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [TICKET_W-1:0] ticket_t;
  typedef logic [WINDOW_W-1:0] window_t;

  typedef enum logic [1:0] {
    FUNC_MATCH  = 2'd0,
    FUNC_LEARN  = 2'd1,
    FUNC_PRESET = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_P      = 2'd1,
    BTN_C      = 2'd2,
    BTN_REPEAT = 2'd3
  } button_t;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_PRESET_P = 4'd1,
    EV_PRESET_C = 4'd2,
    EV_CALL_P   = 4'd3,
    EV_CALL_C   = 4'd4,
    EV_REPEAT   = 4'd5,
    EV_LEARNED  = 4'd6,
    EV_KNOWN    = 4'd7,
    EV_FULL     = 4'd8,
    EV_CLEARED  = 4'd9
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [CODE_W-1:0] code;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]          event_res;
    logic [WINDOW_W-1:0] window;
    logic [TICKET_W-1:0] ticket;
    logic                queue;
  } res_item_t;

  function automatic ticket_t step_count(input ticket_t c);
    if (c == ticket_t'(QUEUE_MOD - 1)) begin
      return '0;
    end
    return c + ticket_t'(1);
  endfunction

  function automatic window_t sat_window(input slot_t s);
    if (32'(s) > 32'(WINDOW_MAX)) begin
      return window_t'(WINDOW_MAX);
    end
    return window_t'(s);
  endfunction

  function automatic logic codes_match(input logic [CODE_W-1:0] entry,
                                       input logic [CODE_W-1:0] code);
    return (entry != '0) && (((entry ^ code) & KEY_MASK) == '0);
  endfunction

endpackage

@@ hw/rtl/lrct_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lrct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/learned_remote_code_table_core.sv @@
// Top level of the learned remote code table: sequencer, scan compare unit,
// queue counters and result register.
// Depends on lrct_pkg and lrct_ram.
//
// Commands arrive on the cmd channel (valid/ready) and each one produces
// exactly one item on the res channel (valid/ready). The preset code lives in
// a register; the call codes live in a RAM with one valid bit per slot.
// A match or learn command scans call slots 1 to SLOTS-1 through the single
// RAM read port, one slot per cycle, with one shared compare unit that
// records the first matching slot and the first empty slot. A new command is
// accepted only after the previous item is through ST_SCAN, ST_DRAIN and
// ST_RESULT. The result of a scan is registered in ST_RESULT, after the last
// slot has been compared in ST_DRAIN. Preset learn and clear need no scan:
// their command goes from ST_IDLE straight to ST_RESULT, where the result is
// registered. If the receiver stalls, the block holds the
// finished result and waits before applying the next one, so nothing is lost
// or repeated; cmd_ready stays low from acceptance until the result of that
// item has been registered.
// Reset empties every slot at once by clearing the valid bits, and clears
// the counters, recorded windows and last queue. No sweep is needed.
module learned_remote_code_table_core
  import lrct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  state_t            state, state_next;
  logic [1:0]        func;
  logic [CODE_W-1:0] code;
  logic [CODE_W-1:0] preset_code;
  logic [SLOTS-1:0]  vld;
  slot_t             addr;
  logic              rd_vld;
  logic              rd_bit;
  slot_t             rd_slot;
  logic [CODE_W-1:0] rd_data;
  logic              found;
  slot_t             hit_slot;
  logic              empty_found;
  slot_t             empty_slot;
  ticket_t           count_p, count_c;
  window_t           window_p, window_c;
  logic              last_queue;

  logic              accept;
  logic              scan_rd;
  logic              fire;
  logic              last_addr;
  logic              entry_used;
  logic              entry_hit;

  res_item_t         res_next;
  logic              step_p, step_c;
  logic              set_win_p, set_win_c;
  logic              ram_we;
  logic              preset_we;
  logic              clear_all;
  button_t           button;

  assign button     = button_t'(code[9:8]);
  assign accept     = cmd_valid && cmd_ready;
  assign last_addr  = (addr == slot_t'(SLOTS - 1));
  assign entry_used = rd_bit && (rd_data != '0);
  assign entry_hit  = rd_bit && codes_match(rd_data, code);

  lrct_ram #(
    .WIDTH(CODE_W),
    .DEPTH(SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(empty_slot),
    .wdata(code),
    .raddr(addr),
    .rdata(rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.func == FUNC_MATCH || cmd.func == FUNC_LEARN) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    scan_rd   = 1'b0;
    fire      = 1'b0;
    unique case (state)
      ST_IDLE:   cmd_ready = 1'b1;
      ST_SCAN:   scan_rd   = 1'b1;
      ST_DRAIN:  ;
      ST_RESULT: fire      = !res_valid || res_ready;
      default:   ;
    endcase
  end

  always_comb begin
    res_next   = '0;
    step_p     = 1'b0;
    step_c     = 1'b0;
    set_win_p  = 1'b0;
    set_win_c  = 1'b0;
    ram_we     = 1'b0;
    preset_we  = 1'b0;
    clear_all  = 1'b0;
    unique case (func_t'(func))
      FUNC_MATCH: begin
        if (codes_match(preset_code, code)) begin
          case (button)
            BTN_P: begin
              step_p             = fire;
              res_next.event_res = EV_PRESET_P;
              res_next.ticket    = step_count(count_p);
            end
            BTN_C: begin
              step_c             = fire;
              res_next.event_res = EV_PRESET_C;
              res_next.ticket    = step_count(count_c);
              res_next.queue     = 1'b1;
            end
            default: ;
          endcase
        end else if (found) begin
          case (button)
            BTN_P: begin
              step_p             = fire;
              set_win_p          = fire;
              res_next.event_res = EV_CALL_P;
              res_next.window    = sat_window(hit_slot);
              res_next.ticket    = step_count(count_p);
            end
            BTN_C: begin
              step_c             = fire;
              set_win_c          = fire;
              res_next.event_res = EV_CALL_C;
              res_next.window    = sat_window(hit_slot);
              res_next.ticket    = step_count(count_c);
              res_next.queue     = 1'b1;
            end
            BTN_REPEAT: begin
              res_next.event_res = EV_REPEAT;
              res_next.queue     = last_queue;
              res_next.ticket    = last_queue ? count_c : count_p;
              res_next.window    = last_queue ? window_c : window_p;
            end
            default: ;
          endcase
        end
      end
      FUNC_LEARN: begin
        if (code != '0) begin
          if (found) begin
            res_next.event_res = EV_KNOWN;
            res_next.window    = sat_window(hit_slot);
          end else if (empty_found) begin
            ram_we             = fire;
            res_next.event_res = EV_LEARNED;
            res_next.window    = sat_window(empty_slot);
          end else begin
            res_next.event_res = EV_FULL;
          end
        end
      end
      FUNC_PRESET: begin
        preset_we          = fire;
        res_next.event_res = EV_LEARNED;
      end
      FUNC_CLEAR: begin
        clear_all          = fire;
        res_next.event_res = EV_CLEARED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      res_valid   <= 1'b0;
      rd_vld      <= 1'b0;
      found       <= 1'b0;
      empty_found <= 1'b0;
      vld         <= '0;
      preset_code <= '0;
      count_p     <= '0;
      count_c     <= '0;
      window_p    <= '0;
      window_c    <= '0;
      last_queue  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= scan_rd;
      if (accept) begin
        found       <= 1'b0;
        empty_found <= 1'b0;
      end else if (rd_vld) begin
        if (entry_hit && !found) begin
          found <= 1'b1;
        end
        if (!entry_used && !empty_found) begin
          empty_found <= 1'b1;
        end
      end
      if (fire) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (step_p) begin
        count_p <= step_count(count_p);
      end
      if (step_c) begin
        count_c <= step_count(count_c);
      end
      if (set_win_p) begin
        window_p   <= sat_window(hit_slot);
        last_queue <= 1'b0;
      end
      if (set_win_c) begin
        window_c   <= sat_window(hit_slot);
        last_queue <= 1'b1;
      end
      if (preset_we) begin
        preset_code <= code;
      end
      if (clear_all) begin
        vld <= '0;
      end else if (ram_we) begin
        vld[empty_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func <= cmd.func;
      code <= cmd.code;
      addr <= slot_t'(1);
    end else if (scan_rd && !last_addr) begin
      addr <= addr + slot_t'(1);
    end
    rd_bit  <= vld[addr];
    rd_slot <= addr;
    if (rd_vld) begin
      if (entry_hit && !found) begin
        hit_slot <= rd_slot;
      end
      if (!entry_used && !empty_found) begin
        empty_slot <= rd_slot;
      end
    end
    if (fire) begin
      res <= res_next;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after accepting an item");

  a_scan_addr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (addr != '0))
    else $error("scan address reached the preset slot");

  a_res_window_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(res.window) <= 32'(WINDOW_MAX)))
    else $error("result window above saturation limit");

  a_res_ticket_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(res.ticket) < 32'(QUEUE_MOD)))
    else $error("result ticket outside queue range");

  a_fire_sets_valid: assert property (@(posedge clk) disable iff (rst)
    fire |=> res_valid)
    else $error("finished result not presented");

endmodule

@@ tb/sv/learned_remote_code_table_core_tb.sv @@
// Self-checking testbench for learned_remote_code_table_core: a directed table,
// a fill of the call slots and random phases with idling on both channels,
// all checked against typed results or a predictor of the code table and counters.
`timescale 1ns / 1ps

module learned_remote_code_table_core_tb
  import lrct_pkg::*;
();

  localparam logic [CODE_W-1:0] BUTTON_BITS = 32'h0000_0300;
  localparam int RUN_LIMIT   = 1_500_000;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASE_ITEMS = 140;
  localparam int FILL_ITEMS  = 130;

  typedef struct {
    cmd_item_t c;
    bit        typed;
    res_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  cmd_item_t cmd;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_item_t res;

  logic [CODE_W-1:0] code_tbl [SLOTS];
  ticket_t           cnt_p;
  ticket_t           cnt_c;
  window_t           win_p;
  window_t           win_c;
  logic              last_q;

  res_item_t pending_res[$];
  int        mismatches     = 0;
  int        cycles         = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  logic      hold_go        = 1'b0;
  logic      rx_hold        = 1'b0;

  learned_remote_code_table_core u_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit same_remote(logic [CODE_W-1:0] entry, logic [CODE_W-1:0] c);
    return (entry != '0) && (((entry ^ c) & ~BUTTON_BITS) == '0);
  endfunction

  function automatic int first_call_hit(logic [CODE_W-1:0] c);
    for (int s = 1; s < SLOTS; s++) begin
      if (same_remote(code_tbl[s], c)) begin
        return s;
      end
    end
    return 0;
  endfunction

  function automatic ticket_t next_ticket(ticket_t t);
    return (t == ticket_t'(QUEUE_MOD - 1)) ? '0 : t + ticket_t'(1);
  endfunction

  function automatic window_t clip_window(int s);
    return (s > WINDOW_MAX) ? window_t'(WINDOW_MAX) : window_t'(s);
  endfunction

  function automatic logic [CODE_W-1:0] with_button(logic [CODE_W-1:0] c, button_t b);
    return (c & ~BUTTON_BITS) | (CODE_W'(b) << 8);
  endfunction

  // Applies one command to the table and counters and returns its result.
  function automatic res_item_t remote_table_step(cmd_item_t c);
    func_t     f;
    button_t   b;
    res_item_t r;
    int        hit;
    bit        stored;
    f      = func_t'(c.func);
    b      = button_t'(c.code[9:8]);
    r      = '0;
    stored = 1'b0;
    case (f)
      FUNC_MATCH: begin
        if (same_remote(code_tbl[0], c.code)) begin
          if (b == BTN_P) begin
            cnt_p       = next_ticket(cnt_p);
            r.event_res = EV_PRESET_P;
            r.ticket    = cnt_p;
          end else if (b == BTN_C) begin
            cnt_c       = next_ticket(cnt_c);
            r.event_res = EV_PRESET_C;
            r.ticket    = cnt_c;
            r.queue     = 1'b1;
          end
        end else begin
          hit = first_call_hit(c.code);
          if (hit != 0) begin
            case (b)
              BTN_P: begin
                cnt_p       = next_ticket(cnt_p);
                win_p       = clip_window(hit);
                last_q      = 1'b0;
                r.event_res = EV_CALL_P;
                r.window    = win_p;
                r.ticket    = cnt_p;
              end
              BTN_C: begin
                cnt_c       = next_ticket(cnt_c);
                win_c       = clip_window(hit);
                last_q      = 1'b1;
                r.event_res = EV_CALL_C;
                r.window    = win_c;
                r.ticket    = cnt_c;
                r.queue     = 1'b1;
              end
              BTN_REPEAT: begin
                r.event_res = EV_REPEAT;
                r.queue     = last_q;
                r.ticket    = last_q ? cnt_c : cnt_p;
                r.window    = last_q ? win_c : win_p;
              end
              default: begin
              end
            endcase
          end
        end
      end
      FUNC_LEARN: begin
        if (c.code != '0) begin
          hit = first_call_hit(c.code);
          if (hit != 0) begin
            r.event_res = EV_KNOWN;
            r.window    = clip_window(hit);
          end else begin
            r.event_res = EV_FULL;
            for (int s = 1; s < SLOTS && !stored; s++) begin
              if (code_tbl[s] == '0) begin
                code_tbl[s] = c.code;
                stored      = 1'b1;
                r.event_res = EV_LEARNED;
                r.window    = clip_window(s);
              end
            end
          end
        end
      end
      FUNC_PRESET: begin
        code_tbl[0] = c.code;
        r.event_res = EV_LEARNED;
      end
      FUNC_CLEAR: begin
        for (int s = 1; s < SLOTS; s++) begin
          code_tbl[s] = '0;
        end
        r.event_res = EV_CLEARED;
      end
    endcase
    return r;
  endfunction

  function automatic int random_call_slot();
    int used[$];
    for (int s = 1; s < SLOTS; s++) begin
      if (code_tbl[s] != '0) begin
        used.push_back(s);
      end
    end
    if (used.size() == 0) begin
      return 0;
    end
    return used[$urandom_range(used.size() - 1)];
  endfunction

  function automatic cmd_item_t learn_cmd();
    cmd_item_t it;
    int        r;
    int        s;
    r       = $urandom_range(99);
    s       = random_call_slot();
    it.func = FUNC_LEARN;
    if (r < 3) begin
      it.code = '0;
    end else if (r < 25 && s != 0) begin
      it.code = with_button(code_tbl[s], button_t'($urandom_range(3)));
    end else begin
      it.code = $urandom;
    end
    return it;
  endfunction

  // Learns a distinct nonzero code for every k, so the call slots fill up.
  function automatic cmd_item_t fill_cmd(int k);
    cmd_item_t it;
    it.func = FUNC_LEARN;
    it.code = 32'h6C00_0001 | (CODE_W'(k) << 10);
    return it;
  endfunction

  function automatic cmd_item_t random_cmd();
    cmd_item_t         it;
    int                r;
    int                s;
    logic [CODE_W-1:0] base;
    r       = $urandom_range(99);
    s       = random_call_slot();
    it.func = FUNC_MATCH;
    it.code = $urandom;
    if (r < 55) begin
      base    = (r < 10 || s == 0) ? code_tbl[0] : code_tbl[s];
      it.code = with_button(base, button_t'($urandom_range(3)));
      if ($urandom_range(9) == 0) begin
        it.code = it.code ^ (32'd1 << $urandom_range(31));
      end
    end else if (r < 75) begin
      it = learn_cmd();
    end else if (r < 82) begin
      it.func = FUNC_PRESET;
      if (r < 79 && s != 0) begin
        it.code = code_tbl[s];
      end else if (r == 81) begin
        it.code = '0;
      end
    end else if (r < 84) begin
      it.func = FUNC_CLEAR;
    end
    return it;
  endfunction

  function automatic dir_row_t dir_row(func_t f, logic [CODE_W-1:0] c, bit typed,
                                       event_t ev = EV_NONE, int win = 0,
                                       int tick = 0, bit q = 1'b0);
    dir_row_t row;
    row.c.func         = f;
    row.c.code         = c;
    row.typed          = typed;
    row.want.event_res = ev;
    row.want.window    = window_t'(win);
    row.want.ticket    = ticket_t'(tick);
    row.want.queue     = q;
    return row;
  endfunction

  task automatic send_cmd(input cmd_item_t it, input bit typed = 1'b0,
                          input res_item_t want = '0);
    res_item_t model;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= it;
    do @(posedge clk); while (!cmd_ready);
    model = remote_table_step(it);
    pending_res.push_back(typed ? want : model);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic check_res(input res_item_t got);
    res_item_t want;
    if (pending_res.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected item: ev=%0d win=%0d tick=%0d q=%0d",
                 got.event_res, got.window, got.ticket, got.queue);
      end
    end else begin
      want = pending_res.pop_front();
      if (got.event_res !== want.event_res || got.window !== want.window ||
          got.ticket !== want.ticket || got.queue !== want.queue) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected ev=%0d win=%0d tick=%0d q=%0d,",
                   want.event_res, want.window, want.ticket, want.queue,
                   " got ev=%0d win=%0d tick=%0d q=%0d",
                   got.event_res, got.window, got.ticket, got.queue);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      check_res(res);
    end
    res_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    cmd_valid = 1'b0;
    cmd       = '0;
    rst       = 1'b1;
    foreach (code_tbl[i]) begin
      code_tbl[i] = '0;
    end
    cnt_p  = '0;
    cnt_c  = '0;
    win_p  = '0;
    win_c  = '0;
    last_q = 1'b0;

    // Rows without a typed result are checked against the predictor.
    dir_rows = '{
      dir_row(FUNC_MATCH,  32'h1234_5601, 1'b1, EV_NONE),
      dir_row(FUNC_LEARN,  32'h0000_0000, 1'b1, EV_NONE),
      dir_row(FUNC_CLEAR,  32'h0000_0000, 1'b1, EV_CLEARED),
      dir_row(FUNC_PRESET, 32'hA5A5_0000, 1'b1, EV_LEARNED),
      dir_row(FUNC_MATCH,  32'hA5A5_0100, 1'b1, EV_PRESET_P, 0, 1, 1'b0),
      dir_row(FUNC_MATCH,  32'hA5A5_0200, 1'b1, EV_PRESET_C, 0, 1, 1'b1),
      dir_row(FUNC_MATCH,  32'hA5A5_0300, 1'b1, EV_NONE),
      dir_row(FUNC_MATCH,  32'hA5A5_0000, 1'b1, EV_NONE),
      dir_row(FUNC_LEARN,  32'hFFFF_FFFF, 1'b1, EV_LEARNED, 1),
      dir_row(FUNC_LEARN,  32'hFFFF_FCFF, 1'b1, EV_KNOWN, 1),
      dir_row(FUNC_MATCH,  32'hFFFF_FFFF, 1'b0),
      dir_row(FUNC_MATCH,  32'hFFFF_FDFF, 1'b0),
      dir_row(FUNC_MATCH,  32'hFFFF_FEFF, 1'b0),
      dir_row(FUNC_MATCH,  32'hFFFF_FFFF, 1'b0),
      dir_row(FUNC_MATCH,  32'hFFFF_FCFF, 1'b1, EV_NONE),
      dir_row(FUNC_LEARN,  32'h0000_0100, 1'b1, EV_LEARNED, 2),
      dir_row(FUNC_MATCH,  32'h0000_0200, 1'b0),
      dir_row(FUNC_MATCH,  32'h0000_0000, 1'b1, EV_NONE),
      dir_row(FUNC_PRESET, 32'h0000_0000, 1'b1, EV_LEARNED),
      dir_row(FUNC_MATCH,  32'h0000_0100, 1'b0),
      dir_row(FUNC_PRESET, 32'hFFFF_FFFF, 1'b1, EV_LEARNED),
      dir_row(FUNC_MATCH,  32'hFFFF_FDFF, 1'b0),
      dir_row(FUNC_CLEAR,  32'h0000_0000, 1'b1, EV_CLEARED),
      dir_row(FUNC_MATCH,  32'h0000_0100, 1'b1, EV_NONE),
      dir_row(FUNC_LEARN,  32'h1234_5678, 1'b1, EV_LEARNED, 1)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_idling(35, 35);
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(54, 0);
        2: set_idling(0, 54);
        default: set_idling(35, 35);
      endcase
      if (ph == 0) begin
        hold_go <= 1'b1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_cmd((ph == 1 && k < FILL_ITEMS) ? fill_cmd(k) : random_cmd());
      end
      drain_results();
    end

    repeat (SLOTS + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
